/* hw/rtl/mmss_pkg.sv */
// Shared types, operation codes and digit-conversion functions for the
// minutes:seconds countdown timer. No dependencies.
package mmss_pkg;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_SEC_UP   = 3'd1;
  localparam logic [2:0] OP_SEC_DOWN = 3'd2;
  localparam logic [2:0] OP_MIN_UP   = 3'd3;
  localparam logic [2:0] OP_MIN_DOWN = 3'd4;

  localparam logic [5:0] SEC_MAX = 6'd59;
  localparam logic [6:0] MIN_MAX = 7'd99;
  localparam logic [7:0] TICKS_PER_COUNT_RESET = 8'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic       set_mode;
  } in_item_t;

  typedef struct packed {
    logic [3:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
  } out_item_t;

  // Tens digit of a value below 100, by multiplying with the reciprocal of ten.
  function automatic logic [3:0] tens_digit(input logic [6:0] value);
    logic [14:0] product;
    product = {8'd0, value} * 15'd205;
    return product[14:11];
  endfunction

  function automatic logic [3:0] units_digit(input logic [6:0] value);
    logic [3:0] tens;
    logic [6:0] remainder;
    tens = tens_digit(value);
    remainder = value - ({3'd0, tens} * 7'd10);
    return remainder[3:0];
  endfunction

endpackage

/* hw/rtl/mm_ss_countdown_timer.sv */
// Top level of the minutes:seconds countdown timer: state update and result register.
// Depends on mmss_pkg for the item types, operation codes and digit functions.
//
// Channel   Direction  Payload               Transfer when
// in        input      mmss_pkg::in_item_t   in_valid & in_ready
// out       output     mmss_pkg::out_item_t  out_valid & out_ready
// cfg       input      ticks_per_count [7:0] cfg_valid & cfg_ready
//
// Each item's result is registered and sits in the output register on the next cycle.
// A new item is taken every cycle while the output register is empty or being drained.
// Reset clears the time and the prescaler and sets ticks_per_count to four.
// A stalled output holds its result and stops input transfers until it is taken.
module mm_ss_countdown_timer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mmss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mmss_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  logic [7:0] ticks_per_count;
  logic [7:0] prescale_count;
  logic [5:0] second_count;
  logic [6:0] minute_count;

  logic [7:0] prescale_count_next;
  logic [5:0] second_count_next;
  logic [6:0] minute_count_next;
  logic [7:0] prescale_inc;
  logic [3:0] second_tens_full;
  logic       in_xfer;

  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign prescale_inc = prescale_count + 8'd1;
  assign second_tens_full = mmss_pkg::tens_digit({1'b0, second_count_next});

  always_comb begin
    prescale_count_next = prescale_count;
    second_count_next   = second_count;
    minute_count_next   = minute_count;
    if (in_data.operation == mmss_pkg::OP_TICK) begin
      if (!in_data.set_mode && prescale_inc == ticks_per_count) begin
        if (second_count == 6'd0) begin
          if (minute_count != 7'd0) begin
            minute_count_next = minute_count - 7'd1;
            second_count_next = mmss_pkg::SEC_MAX;
          end
        end else begin
          second_count_next = second_count - 6'd1;
        end
      end
      prescale_count_next = (prescale_inc >= ticks_per_count) ? 8'd0 : prescale_inc;
    end else if (in_data.set_mode) begin
      unique case (in_data.operation)
        mmss_pkg::OP_SEC_UP: begin
          second_count_next = (second_count >= mmss_pkg::SEC_MAX) ? 6'd0
                                                                  : second_count + 6'd1;
        end
        mmss_pkg::OP_SEC_DOWN: begin
          second_count_next = (second_count == 6'd0 || second_count > mmss_pkg::SEC_MAX)
                              ? mmss_pkg::SEC_MAX : second_count - 6'd1;
        end
        mmss_pkg::OP_MIN_UP: begin
          minute_count_next = (minute_count >= mmss_pkg::MIN_MAX) ? 7'd0
                                                                  : minute_count + 7'd1;
        end
        mmss_pkg::OP_MIN_DOWN: begin
          minute_count_next = (minute_count == 7'd0 || minute_count > mmss_pkg::MIN_MAX)
                              ? mmss_pkg::MIN_MAX : minute_count - 7'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_count <= mmss_pkg::TICKS_PER_COUNT_RESET;
      prescale_count  <= 8'd0;
      second_count    <= 6'd0;
      minute_count    <= 7'd0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ticks_per_count <= cfg_data;
      end
      if (in_xfer) begin
        prescale_count <= prescale_count_next;
        second_count   <= second_count_next;
        minute_count   <= minute_count_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data.minute_tens  <= mmss_pkg::tens_digit(minute_count_next);
      out_data.minute_units <= mmss_pkg::units_digit(minute_count_next);
      out_data.second_tens  <= second_tens_full[2:0];
      out_data.second_units <= mmss_pkg::units_digit({1'b0, second_count_next});
    end
  end

endmodule

/* verif/tb_mm_ss_countdown_timer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the minutes:seconds countdown timer.
// Depends on mmss_pkg and mm_ss_countdown_timer; ticks and button presses are checked
// against an in-bench model of the time, with random idling on the input and output channels.
module tb_mm_ss_countdown_timer;

  class countdown_tracker;
    logic [7:0]          step_ticks;
    logic [7:0]          prescale;
    logic [5:0]          secs;
    logic [6:0]          mins;
    mmss_pkg::out_item_t expected_digits[$];
    int                  errors;

    function new();
      step_ticks = mmss_pkg::TICKS_PER_COUNT_RESET;
      prescale   = '0;
      secs       = '0;
      mins       = '0;
      errors     = 0;
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("%0t ns: %s", $time, what);
    endtask

    function void count_down();
      if (secs == 6'd0) begin
        if (mins != 7'd0) begin
          mins = mins - 7'd1;
          secs = mmss_pkg::SEC_MAX;
        end
      end else begin
        secs = secs - 6'd1;
      end
    endfunction

    function void note_item(mmss_pkg::in_item_t it);
      mmss_pkg::out_item_t d;
      if (it.operation == mmss_pkg::OP_TICK) begin
        prescale = prescale + 8'd1;
        if (!it.set_mode && prescale == step_ticks) begin
          count_down();
        end
        if (prescale >= step_ticks) begin
          prescale = '0;
        end
      end else if (it.set_mode) begin
        unique case (it.operation)
          mmss_pkg::OP_SEC_UP: begin
            secs = (secs >= mmss_pkg::SEC_MAX) ? 6'd0 : secs + 6'd1;
          end
          mmss_pkg::OP_SEC_DOWN: begin
            secs = (secs == 6'd0 || secs > mmss_pkg::SEC_MAX) ? mmss_pkg::SEC_MAX
                                                                : secs - 6'd1;
          end
          mmss_pkg::OP_MIN_UP: begin
            mins = (mins >= mmss_pkg::MIN_MAX) ? 7'd0 : mins + 7'd1;
          end
          mmss_pkg::OP_MIN_DOWN: begin
            mins = (mins == 7'd0 || mins > mmss_pkg::MIN_MAX) ? mmss_pkg::MIN_MAX
                                                                : mins - 7'd1;
          end
          default: begin
          end
        endcase
      end
      d.minute_tens  = 4'(mins / 7'd10);
      d.minute_units = 4'(mins % 7'd10);
      d.second_tens  = 3'(secs / 6'd10);
      d.second_units = 4'(secs % 6'd10);
      expected_digits.push_back(d);
    endfunction

    task check_field(string name, int got, int want);
      if (got != want) begin
        flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
    endtask

    task check_digits(mmss_pkg::out_item_t got);
      mmss_pkg::out_item_t want;
      if (expected_digits.size() == 0) begin
        flag_mismatch("result transfer with no item outstanding");
      end else begin
        want = expected_digits.pop_front();
        check_field("minute_tens", got.minute_tens, want.minute_tens);
        check_field("minute_units", got.minute_units, want.minute_units);
        check_field("second_tens", got.second_tens, want.second_tens);
        check_field("second_units", got.second_units, want.second_units);
      end
    endtask

    function int pending();
      return expected_digits.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mmss_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mmss_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = '0;

  countdown_tracker tracker = new();
  bit hold_out = 1'b0;
  bit rx_fast  = 1'b0;
  bit tx_fast  = 1'b0;

  mm_ss_countdown_timer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        tracker.step_ticks = cfg_data;
      end
      if (in_valid && in_ready) begin
        tracker.note_item(in_data);
      end
      if (out_valid && out_ready) begin
        tracker.check_digits(out_data);
      end
    end
  end

  initial begin
    int stall;
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end else begin
        stall = (rx_fast || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(logic [2:0] op, logic set_on);
    int gap;
    mmss_pkg::in_item_t it;
    gap = (tx_fast || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.operation = op;
    it.set_mode  = set_on;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_step_ticks(logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_item(mmss_pkg::OP_TICK, $urandom_range(0, 9) == 0);
    end else if (pick < 90) begin
      send_item(3'($urandom_range(1, 4)), $urandom_range(0, 9) != 0);
    end else begin
      send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [7:0] phase_ticks[6];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // At 00:00 the countdown holds; buttons do nothing outside set mode, undefined codes nothing in it.
    repeat (4) send_item(mmss_pkg::OP_TICK, 1'b0);
    send_item(mmss_pkg::OP_SEC_UP, 1'b0);
    send_item(mmss_pkg::OP_SEC_DOWN, 1'b0);
    send_item(mmss_pkg::OP_MIN_UP, 1'b0);
    send_item(mmss_pkg::OP_MIN_DOWN, 1'b0);
    send_item(3'd5, 1'b1);
    send_item(3'd6, 1'b1);
    send_item(3'd7, 1'b1);
    // Wrap in both directions, then borrow from the minutes.
    send_item(mmss_pkg::OP_SEC_DOWN, 1'b1);
    send_item(mmss_pkg::OP_MIN_DOWN, 1'b1);
    send_item(mmss_pkg::OP_SEC_UP, 1'b1);
    send_item(mmss_pkg::OP_MIN_UP, 1'b1);
    send_item(mmss_pkg::OP_MIN_UP, 1'b1);
    repeat (2) send_item(mmss_pkg::OP_TICK, 1'b1);
    repeat (4) send_item(mmss_pkg::OP_TICK, 1'b0);

    // Lowering the step count below the prescaler value clears it without a countdown.
    write_step_ticks(8'd255);
    repeat (4) send_item(mmss_pkg::OP_TICK, 1'b0);
    write_step_ticks(8'd2);
    repeat (2) send_item(mmss_pkg::OP_TICK, 1'b0);

    phase_ticks = '{8'd1, 8'd2, 8'd255, 8'd0, 8'($urandom_range(3, 12)), 8'd1};
    for (int p = 0; p < 6; p++) begin
      write_step_ticks(phase_ticks[p]);
      rx_fast = (p % 2 == 1);
      tx_fast = (p % 3 == 2);
      if (p == 1) begin
        hold_out = 1'b1;
      end
      repeat (300) random_item();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (tracker.pending() != 0) begin
      tracker.flag_mismatch($sformatf("%0d results never arrived", tracker.pending()));
    end
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mmss_pkg.sv
hw/rtl/mm_ss_countdown_timer.sv
verif/tb_mm_ss_countdown_timer.sv
